[hw/rtl/ird_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_pkg: shared types and constants for the radix digit converter
// Word layouts, digit store sizing and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package ird_pkg;

	// sizing
	localparam int VALUE_WIDTH = 64;   // bits of the operand that are converted
	localparam int MAX_DIGITS  = 64;   // digits kept per conversion
	localparam int IDX_W       = $clog2(MAX_DIGITS);
	localparam int STEP_W      = $clog2(VALUE_WIDTH);

	// field widths
	localparam int OPERAND_W = 64;
	localparam int BASE_W    = 6;
	localparam int REM_W     = 6;
	localparam int CHAR_W    = 7;

	// radix limits
	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

	// character constants
	localparam logic [CHAR_W-1:0] CHAR_ZERO      = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_LETTER_A  = CHAR_W'(65);
	localparam logic [REM_W-1:0]  DECIMAL_DIGITS = REM_W'(10);

	// input word
	typedef struct packed {
		logic signed [OPERAND_W-1:0] value;
		logic        [BASE_W-1:0]    base;
	} in_word_t;

	// result word, one per digit
	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              negative;
		logic              last;
	} out_word_t;

	// digit value to '0'-'9', 'A'-'Z'
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LETTER_A + CHAR_W'(d - DECIMAL_DIGITS);
		end
		return c;
	endfunction

endpackage

[hw/rtl/ird_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_divider: radix-2 restoring divider
// Divides a VALUE_WIDTH-bit dividend by a small radix, one quotient bit per
// cycle. Quotient and remainder are valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module ird_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [ird_pkg::VALUE_WIDTH-1:0]       dividend,
	input  logic [ird_pkg::BASE_W-1:0]            divisor,
	output logic                                  done,
	output logic [ird_pkg::VALUE_WIDTH-1:0]       quotient,
	output logic [ird_pkg::REM_W-1:0]             remainder
);

	logic                                run_q;
	logic                                done_q;
	logic [ird_pkg::STEP_W-1:0]          step_q;
	logic [ird_pkg::VALUE_WIDTH-1:0]     quo_q;
	logic [ird_pkg::REM_W-1:0]           rem_q;
	logic [ird_pkg::BASE_W-1:0]          div_q;

	logic [ird_pkg::REM_W:0]             trial;
	logic [ird_pkg::REM_W:0]             diff;
	logic                                ge;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[ird_pkg::VALUE_WIDTH-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == ird_pkg::STEP_W'(ird_pkg::VALUE_WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder stays below the divisor, so it fits REM_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[ird_pkg::VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[ird_pkg::REM_W-1:0] : trial[ird_pkg::REM_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/integer_to_radix_digits.sv]
`timescale 1ns / 1ps
// Each digit is computed on the shared radix-2 divider, then read back from the
//   digit store in ST_READ and emitted in ST_EMIT.
// busy stays high for a whole item, from acceptance until its final digit leaves.
// Digits leave one per strobe, most significant first; the receiver cannot stall.
// Reset clears the sequencer and divider control; the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to radix 2..36 ASCII digits
// Forms the unsigned magnitude, divides repeatedly by the radix, stores the
// remainders and plays them back most significant first.
// ----------------------------------------------------------------------------
module integer_to_radix_digits (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ird_pkg::in_word_t    req,
	output logic                 digit_valid,
	output ird_pkg::out_word_t   digit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                          state_q;
	logic [ird_pkg::IDX_W-1:0]           cnt_q;
	logic                                sign_q;
	logic [ird_pkg::BASE_W-1:0]          base_q;
	logic [ird_pkg::REM_W-1:0]           rd_q;
	logic [ird_pkg::REM_W-1:0]           store_mem [ird_pkg::MAX_DIGITS];

	logic                                accept;
	logic [ird_pkg::VALUE_WIDTH-1:0]     v;
	logic                                v_sign;
	logic [ird_pkg::VALUE_WIDTH-1:0]     mag;
	logic [ird_pkg::BASE_W-1:0]          base_sat;
	logic                                more;

	logic                                div_start;
	logic [ird_pkg::VALUE_WIDTH-1:0]     div_dividend;
	logic [ird_pkg::BASE_W-1:0]          div_divisor;
	logic                                div_done;
	logic [ird_pkg::VALUE_WIDTH-1:0]     div_quo;
	logic [ird_pkg::REM_W-1:0]           div_rem;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;

	// magnitude as unsigned, radix saturated into range
	always_comb begin
		v      = req.value[ird_pkg::VALUE_WIDTH-1:0];
		v_sign = v[ird_pkg::VALUE_WIDTH-1];
		mag    = v_sign ? (~v + 1'b1) : v;
		if (req.base < ird_pkg::BASE_MIN) begin
			base_sat = ird_pkg::BASE_MIN;
		end else if (req.base > ird_pkg::BASE_MAX) begin
			base_sat = ird_pkg::BASE_MAX;
		end else begin
			base_sat = req.base;
		end
	end

	// another digit while the quotient is nonzero and the store has room
	assign more = (div_quo != '0) &&
		(cnt_q != ird_pkg::IDX_W'(ird_pkg::MAX_DIGITS - 1));

	// divider launch: first digit from the magnitude, later ones from the quotient
	always_comb begin
		div_start    = 1'b0;
		div_dividend = div_quo;
		div_divisor  = base_q;
		if (accept) begin
			div_start    = 1'b1;
			div_dividend = mag;
			div_divisor  = base_sat;
		end else if ((state_q == ST_DIV) && div_done && more) begin
			div_start = 1'b1;
		end
	end

	ird_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sign_q  <= 1'b0;
			base_q  <= ird_pkg::BASE_MIN;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						sign_q  <= v_sign;
						base_q  <= base_sat;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (more) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit store, least significant digit at index zero
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			store_mem[cnt_q] <= div_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= store_mem[cnt_q];
		end
	end

	// result word
	assign digit_valid      = state_q == ST_EMIT;
	assign digit.digit_char = ird_pkg::digit_to_ascii(rd_q);
	assign digit.negative   = sign_q;
	assign digit.last       = cnt_q == '0;

	// checks
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> busy)
		else $error("digit strobe outside a conversion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit.last |=> !busy)
		else $error("block still busy after the final digit");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !digit_valid)
		else $error("accepted word did not start a conversion");

endmodule
